// ===== src/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

   localparam int PAT_BYTES   = 32;
   localparam int PAT_WORDS   = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int MATCH_OFF_W = 32;
   localparam int PAT_LEN_W   = 6;

   localparam logic [CSR_IDX_W-1:0] REG_PAT_LO     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_MID_LO = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_MID_HI = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_HI     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CARE_MASK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_LEN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_FIRST = 3'd6;

   typedef struct packed {
      logic [8*PAT_BYTES-1:0] pattern;
      logic [PAT_BYTES-1:0]   care;
      logic [PAT_LEN_W-1:0]   length;
      logic                   stop_at_first;
   } cfg_type;

   typedef struct packed {
      logic                   hit;
      logic [MATCH_OFF_W-1:0] offset;
   } hit_type;

endpackage

`default_nettype wire

// ===== src/mbps_csr.sv =====
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration registers: pattern bytes, care mask, length, stop mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbps_csr
   import mbps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   logic [PAT_WORDS-1:0][CSR_DATA_W-1:0] pat_ff, pat_in;
   logic [PAT_BYTES-1:0]                 care_ff, care_in;
   logic [PAT_LEN_W-1:0]                 len_ff, len_in;
   logic                                 stop_ff, stop_in;
   logic                                 wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      pat_in  = pat_ff;
      care_in = care_ff;
      len_in  = len_ff;
      stop_in = stop_ff;
      if (wr) begin
         case (csr_index)
            REG_PAT_LO:     pat_in[0] = csr_data;
            REG_PAT_MID_LO: pat_in[1] = csr_data;
            REG_PAT_MID_HI: pat_in[2] = csr_data;
            REG_PAT_HI:     pat_in[3] = csr_data;
            REG_CARE_MASK:  care_in   = csr_data[PAT_BYTES-1:0];
            REG_PAT_LEN:    len_in    = csr_data[PAT_LEN_W-1:0];
            REG_STOP_FIRST: stop_in   = csr_data[0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         care_ff <= '1;
         len_ff  <= PAT_LEN_W'(1);
         stop_ff <= 1'b0;
      end else begin
         pat_ff  <= pat_in;
         care_ff <= care_in;
         len_ff  <= len_in;
         stop_ff <= stop_in;
      end
   end

   assign cfg.pattern       = pat_ff;
   assign cfg.care          = care_ff;
   assign cfg.length        = len_ff;
   assign cfg.stop_at_first = stop_ff;

endmodule

`default_nettype wire

// ===== src/mbps_matcher.sv =====
// ----------------------------------------------------------------------------
// mbps_matcher
// Byte window, scan counter and parallel masked compare of every window byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbps_matcher
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = 32,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       take,
   input  wire logic [7:0] data_byte,
   input  wire logic       scan_start,
   output hit_type         result
);

   localparam int FULL_D = (MAX_PATTERN > 1) ? MAX_PATTERN : 2;
   localparam int WIN_D  = FULL_D - 1;
   localparam int AGE_W  = $clog2(FULL_D);
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

   logic [WIN_D-1:0][7:0]  win_ff, win_in;
   logic [FULL_D-1:0][7:0] full;
   logic [OFFSET_BITS-1:0] cnt_ff, cnt_in, cnt_base, cnt_next, off_full;
   logic                   stop_ff, stop_in, stop_base;
   logic [LEN_W-1:0]       len;
   logic [MAX_PATTERN-1:0] byte_ok;
   logic                   counting, check, hit;

   // clamp the configured length into 1..MAX_PATTERN
   always_comb begin
      if (cfg.length == '0) begin
         len = LEN_W'(1);
      end else if (7'(cfg.length) > 7'(MAX_PATTERN)) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = LEN_W'(cfg.length);
      end
   end

   // newest byte at age zero, then the stored window
   always_comb begin
      full = '0;
      full[0] = data_byte;
      for (int k = 1; k < FULL_D; k++) begin
         full[k] = win_ff[k-1];
      end
   end

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
      if (i < PAT_BYTES) begin : g_care
         logic [LEN_W-1:0] age;
         assign age = len - LEN_W'(i) - LEN_W'(1);
         assign byte_ok[i] = (LEN_W'(i) >= len) || !cfg.care[i] ||
                             (full[age[AGE_W-1:0]] == cfg.pattern[8*i +: 8]);
      end else begin : g_wild
         assign byte_ok[i] = 1'b1;
      end
   end

   assign cnt_base  = scan_start ? '0 : cnt_ff;
   assign stop_base = scan_start ? 1'b0 : stop_ff;
   assign counting  = (cnt_base != CNT_MAX);
   assign cnt_next  = cnt_base + OFFSET_BITS'(1);
   assign check     = counting && !stop_base && (cnt_next >= OFFSET_BITS'(len));
   assign hit       = take && check && (&byte_ok);
   assign off_full  = cnt_next - OFFSET_BITS'(len);

   always_comb begin
      win_in  = win_ff;
      cnt_in  = cnt_ff;
      stop_in = stop_ff;
      if (take) begin
         // advance the window by one byte
         win_in[0] = data_byte;
         for (int k = 1; k < WIN_D; k++) begin
            win_in[k] = win_ff[k-1];
         end
         cnt_in  = counting ? cnt_next : cnt_base;
         stop_in = stop_base | (hit & cfg.stop_at_first);
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
      end
   end

   assign result.hit    = hit;
   assign result.offset = MATCH_OFF_W'(off_full);

endmodule

`default_nettype wire

// ===== src/mbps_out_buf.sv =====
// ----------------------------------------------------------------------------
// mbps_out_buf
// Result register with one skid entry between the matcher and the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbps_out_buf
   import mbps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hit_type                result,
   output logic                        space,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [MATCH_OFF_W-1:0]      rsp_match_offset
);

   logic                   out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   logic [MATCH_OFF_W-1:0] out_ff, out_in, skid_ff, skid_in;
   logic                   pop;

   assign space = !skid_vld_ff;
   assign pop   = out_vld_ff & rsp_ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (result.hit) begin
         if (!out_vld_ff || pop) begin
            out_in     = result.offset;
            out_vld_in = 1'b1;
         end else begin
            // hold the new beat behind the stalled one
            skid_in     = result.offset;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_match_offset = out_ff;

endmodule

`default_nettype wire

// ===== src/masked_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams bytes and reports the start offset of each masked pattern match.
//
// req_ beats carry one byte and a scan_start flag; a set flag makes that byte
// offset zero of a new scan and clears the byte count and the stopped state.
// All pattern positions are compared in parallel in the cycle the byte is
// taken, so one byte is taken per cycle while req_ready is high. A match
// is registered into the output register, or the skid entry while rsp_ is
// stalled, and leaves as a rsp_ beat. Bytes completing no match give no beat.
// csr_ writes load the pattern, care mask, length and stop mode; csr_ready
// is always high; the user must write while the stream is idle (unchecked).
// The result path holds two beats (output register plus skid entry); a
// stalled receiver drops req_ready only once both are full.
// Synchronous reset clears the count, the stopped state and the result
// path and loads the register defaults (care mask all ones, length one).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scanner
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = 32,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_scan_start,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [MATCH_OFF_W-1:0]      rsp_match_offset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;
   hit_type result;
   logic    space;
   logic    take;

   assign req_ready = space;
   assign take      = req_valid & space;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbps_matcher #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_matcher (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .take       (take),
      .data_byte  (req_data_byte),
      .scan_start (req_scan_start),
      .result     (result)
   );

   mbps_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .result           (result),
      .space            (space),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_match_offset (rsp_match_offset)
   );

endmodule

`default_nettype wire
